// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/vad_pkg.sv =====
`default_nettype none

package vad_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int PROB_W   = 8;
    localparam int FS_W     = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    // Register widths
    localparam int CAL_W   = 10;
    localparam int FACT_W  = 8;
    localparam int RUN_W   = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CSUM_W  = 26;
    localparam int NF_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_FRAMES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_FACTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HANGOVER    = 2'd3;

    // Register defaults
    localparam logic [CAL_W-1:0]  CAL_FRAMES_DEF = 10'd100;
    localparam logic [FACT_W-1:0] THR_FACTOR_DEF = 8'd48;
    localparam logic [RUN_W-1:0]  MIN_SPEECH_DEF = 10'd3;
    localparam logic [RUN_W-1:0]  HANGOVER_DEF   = 10'd50;

    // Frame states
    localparam logic [FS_W-1:0] FS_SILENCE = 2'd0;
    localparam logic [FS_W-1:0] FS_SPEECH  = 2'd1;
    localparam logic [FS_W-1:0] FS_END     = 2'd2;

    // Decision constants
    localparam logic [NF_W-1:0]   FLOOR_MIN  = 16'd50;
    localparam logic [PROB_W-1:0] PROB_LIMIT = 8'd153;
    localparam logic [RUN_W-1:0]  RUN_MAX    = 10'd1023;

    // Square root unit: radicand covers the largest mean square (2^30)
    localparam int SQ_IN_W = 32;
    localparam int ROOT_W  = 16;

    // Digit-serial squaring
    localparam int DIGIT_W = 4;

    localparam int MAX_FRAME_DEF = 1024;

endpackage

`default_nettype wire

// ===== hw/rtl/energy_voice_activity_detector_core.sv =====
// Sequence: each sample is accepted and, while the frame has room, squared in
// four 4-bit digit steps of the multiply-accumulate; s_tready is low meanwhile.
// A frame-end sample then runs the mean-square divide, the root, the decision and the
// load of the output register, which waits for the receiver; the frame that closes
// calibration adds the noise-floor divide before that load.
// Reset: aresetn is synchronous, active low; clears control state, loads register defaults.
`default_nettype none
`include "assert_macros.svh"

module energy_voice_activity_detector_core #(
    parameter int MAX_FRAME = vad_pkg::MAX_FRAME_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [vad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vad_pkg::CFG_W-1:0]      cfg_wdata,

    // Sample stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [vad_pkg::S_DATA_W-1:0]   s_tdata,   // [15:0] sample, [23:16] speech_prob
    input  wire logic                           s_tlast,   // frame_end

    // Frame state stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [vad_pkg::M_DATA_W-1:0]   m_tdata    // [1:0] frame_state, rest zero
);

    import vad_pkg::*;

    localparam int CNT_W   = $clog2(MAX_FRAME + 1);
    localparam int EN_W    = 2 * SAMPLE_W - 1 + $clog2(MAX_FRAME);
    localparam int DVS_W   = (CNT_W > CAL_W) ? CNT_W : CAL_W;
    localparam int MCAND_W = 2 * SAMPLE_W;
    localparam int DIGITS  = SAMPLE_W / DIGIT_W;
    localparam int DCNT_W  = $clog2(DIGITS);
    localparam int THR_W   = NF_W + FACT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DGO  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;
    localparam logic [2:0] S_CDIV = 3'd6;
    localparam logic [2:0] S_PUSH = 3'd7;

    // Configuration registers
    logic [CAL_W-1:0]  cal_frames_reg;
    logic [FACT_W-1:0] thr_factor_reg;
    logic [RUN_W-1:0]  min_speech_reg;
    logic [RUN_W-1:0]  hangover_reg;

    // Control and state
    logic [2:0]        state_reg, state_next;
    logic [DCNT_W-1:0] dig_cnt_reg;
    logic              fend_reg;
    logic [PROB_W-1:0] prob_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [SAMPLE_W-1:0] digit_reg;
    logic [EN_W-1:0]   energy_reg;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [ROOT_W-1:0] rms_reg;
    logic [CAL_W-1:0]  calib_count_reg, calib_count_next;
    logic [CSUM_W-1:0] calib_sum_reg, calib_sum_next;
    logic [NF_W-1:0]   floor_level_reg;
    logic [RUN_W-1:0]  speech_run_reg, speech_run_next;
    logic [RUN_W-1:0]  silence_run_reg, silence_run_next;
    logic              talking_reg, talking_next;
    logic [FS_W-1:0]   res_reg, res_next;
    logic              m_tvalid_reg;
    logic [FS_W-1:0]   m_state_reg;

    // Handshake and datapath helpers
    logic                   s_fire;
    logic                   room;
    logic [SAMPLE_W-1:0]    raw;
    logic [SAMPLE_W-1:0]    mag;
    logic [MCAND_W+DIGIT_W-1:0] pp;
    logic                   div_go;
    logic [EN_W-1:0]        div_dividend;
    logic [DVS_W-1:0]       div_divisor;
    logic                   div_done;
    logic [EN_W-1:0]        div_quo;
    logic                   sq_go;
    logic                   sq_done;
    logic [ROOT_W-1:0]      sq_root;
    logic                   calibrating;
    logic                   cal_close;
    logic                   speech;
    logic [THR_W-1:0]       thr;
    logic [THR_W-1:0]       rms_x16;
    logic [RUN_W-1:0]       sr_inc;
    logic [RUN_W-1:0]       sil_inc;
    logic [NF_W-1:0]        floor_q;
    logic                   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign room     = sample_count_reg < CNT_W'(MAX_FRAME);
    assign raw      = s_tdata[SAMPLE_W-1:0];
    assign mag      = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;
    assign pp       = mcand_reg * digit_reg[DIGIT_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_frames_reg <= CAL_FRAMES_DEF;
            thr_factor_reg <= THR_FACTOR_DEF;
            min_speech_reg <= MIN_SPEECH_DEF;
            hangover_reg   <= HANGOVER_DEF;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAL_FRAMES: cal_frames_reg <= cfg_wdata[CAL_W-1:0];
                REG_THR_FACTOR: thr_factor_reg <= cfg_wdata[FACT_W-1:0];
                REG_MIN_SPEECH: min_speech_reg <= cfg_wdata[RUN_W-1:0];
                REG_HANGOVER:   hangover_reg   <= cfg_wdata[RUN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Frame decision
    always_comb begin
        calibrating      = calib_count_reg < cal_frames_reg;
        calib_sum_next   = calib_sum_reg + CSUM_W'(rms_reg);
        calib_count_next = calib_count_reg + 1'b1;
        cal_close        = calibrating && (calib_count_next == cal_frames_reg);
        thr              = floor_level_reg * thr_factor_reg;
        rms_x16          = {(THR_W - ROOT_W - 4)'(0), rms_reg, 4'b0000};
        speech           = (rms_x16 > thr) || (prob_reg > PROB_LIMIT);
        sr_inc           = (speech_run_reg < RUN_MAX) ? speech_run_reg + 1'b1 : RUN_MAX;
        sil_inc          = (silence_run_reg < RUN_MAX) ? silence_run_reg + 1'b1 : RUN_MAX;

        speech_run_next  = speech_run_reg;
        silence_run_next = silence_run_reg;
        talking_next     = talking_reg;
        res_next         = FS_SILENCE;

        if (!calibrating) begin
            if (!talking_reg) begin
                if (speech) begin
                    speech_run_next  = sr_inc;
                    silence_run_next = '0;
                    if (sr_inc >= min_speech_reg) begin
                        talking_next = 1'b1;
                        res_next     = FS_SPEECH;
                    end
                end else begin
                    speech_run_next = '0;
                end
            end else if (speech) begin
                silence_run_next = '0;
                res_next         = FS_SPEECH;
            end else if (sil_inc >= hangover_reg) begin
                talking_next     = 1'b0;
                speech_run_next  = '0;
                silence_run_next = '0;
                res_next         = FS_END;
            end else begin
                silence_run_next = sil_inc;
                res_next         = FS_SPEECH;
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        div_go       = 1'b0;
        sq_go        = 1'b0;
        div_dividend = energy_reg;
        div_divisor  = DVS_W'(sample_count_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (room) begin
                        state_next = S_MUL;
                    end else if (s_tlast) begin
                        state_next = S_DGO;
                    end
                end
            end
            S_MUL: begin
                if (dig_cnt_reg == DCNT_W'(DIGITS - 1)) begin
                    state_next = fend_reg ? S_DGO : S_IDLE;
                end
            end
            S_DGO: begin
                div_go     = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    sq_go      = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                div_dividend = EN_W'(calib_sum_next);
                div_divisor  = DVS_W'(cal_frames_reg);
                if (cal_close) begin
                    div_go     = 1'b1;
                    state_next = S_CDIV;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_CDIV: begin
                if (div_done) begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            dig_cnt_reg      <= '0;
            energy_reg       <= '0;
            sample_count_reg <= '0;
            calib_count_reg  <= '0;
            calib_sum_reg    <= '0;
            floor_level_reg  <= '0;
            speech_run_reg   <= '0;
            silence_run_reg  <= '0;
            talking_reg      <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Squaring: one 4-bit digit of the magnitude per cycle
            if (s_fire && room) begin
                sample_count_reg <= sample_count_reg + 1'b1;
                dig_cnt_reg      <= '0;
            end else if (state_reg == S_MUL) begin
                energy_reg  <= energy_reg + EN_W'(pp[MCAND_W-1:0]);
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
            end else if (state_reg == S_DGO) begin
                energy_reg       <= '0;
                sample_count_reg <= '0;
            end

            // Decision updates
            if (state_reg == S_DEC) begin
                if (calibrating) begin
                    calib_sum_reg   <= calib_sum_next;
                    calib_count_reg <= calib_count_next;
                end
                speech_run_reg  <= speech_run_next;
                silence_run_reg <= silence_run_next;
                talking_reg     <= talking_next;
            end

            if (state_reg == S_CDIV && div_done) begin
                floor_level_reg <= floor_q;
            end

            // Output register
            if (state_reg == S_PUSH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign floor_q = (div_quo[NF_W-1:0] < FLOOR_MIN) ? FLOOR_MIN : div_quo[NF_W-1:0];

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fend_reg  <= s_tlast;
            prob_reg  <= s_tdata[SAMPLE_W +: PROB_W];
            mcand_reg <= MCAND_W'(mag);
            digit_reg <= mag;
        end else if (state_reg == S_MUL) begin
            mcand_reg <= {mcand_reg[MCAND_W-DIGIT_W-1:0], DIGIT_W'(0)};
            digit_reg <= {DIGIT_W'(0), digit_reg[SAMPLE_W-1:DIGIT_W]};
        end
        if (state_reg == S_SQRT && sq_done) begin
            rms_reg <= sq_root;
        end
        if (state_reg == S_DEC) begin
            res_reg <= res_next;
        end
        if (state_reg == S_PUSH && out_free) begin
            m_state_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'(m_state_reg);

    // Shared divider: frame mean square, then noise floor
    vad_div #(
        .DVD_W (EN_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    vad_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (sq_go),
        .radicand (div_quo[SQ_IN_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Checks
    `ASSERT_CLK(a_end_reported, aclk, aresetn,
        $fell(talking_reg) && $past(aresetn) |-> (state_reg == S_PUSH) && (res_reg == FS_END),
        "speech left without a speech-ended result")
    `ASSERT_CLK(a_start_reported, aclk, aresetn,
        $rose(talking_reg) |-> (state_reg == S_PUSH) && (res_reg == FS_SPEECH),
        "speech entered without a speech result")
    `ASSERT_CLK(a_div_owner, aclk, aresetn,
        div_done |-> (state_reg == S_DIV) || (state_reg == S_CDIV),
        "divider finished with no waiting state")
    `ASSERT_NEVER(a_count_bound, aclk, aresetn,
        sample_count_reg > CNT_W'(MAX_FRAME),
        "frame sample count beyond limit")

endmodule

`default_nettype wire

// ===== hw/rtl/vad_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module vad_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             go,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] rem_sh;
    logic [DVS_W:0] diff;
    logic           ge;

    // One trial subtraction
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        diff     = rem_sh - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (go) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/vad_isqrt.sv =====
`default_nettype none

// Integer square root, one root bit (two radicand bits) per cycle.
module vad_isqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         go,
    input  wire logic [vad_pkg::SQ_IN_W-1:0]  radicand,
    output logic                              done,
    output logic      [vad_pkg::ROOT_W-1:0]   root
);

    import vad_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_IN_W-1:0] x_reg;
    logic [ROOT_W:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    // One digit step
    always_comb begin
        rem_sh = {rem_reg, x_reg[SQ_IN_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
        diff   = rem_sh - trial;
        if (ge) begin
            rem_next  = diff[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (go) begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== verif/energy_voice_activity_detector_core_tb.sv =====
module energy_voice_activity_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vad_pkg::*;

    localparam int MAX_FRAME    = MAX_FRAME_DEF;
    localparam int STALL_LIMIT  = 3000;  // cycles without a handshake on either stream
    localparam int DRAIN_CYCLES = 150;   // covers root, decision and noise-floor divide
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 45;

    // Keeps its own copy of the detector state and the expected frame states
    class frame_state_scoreboard;
        bit [CAL_W-1:0]  cal_frames = CAL_FRAMES_DEF;
        bit [FACT_W-1:0] thr_factor = THR_FACTOR_DEF;
        bit [RUN_W-1:0]  min_speech = MIN_SPEECH_DEF;
        bit [RUN_W-1:0]  hangover   = HANGOVER_DEF;

        bit [40:0]       energy_sum;
        bit [10:0]       sample_count;
        bit [CAL_W-1:0]  calib_count;
        bit [CSUM_W-1:0] calib_sum;
        bit [NF_W-1:0]   floor_level;
        bit [RUN_W-1:0]  speech_run;
        bit [RUN_W-1:0]  silence_run;
        bit              talking;

        logic [FS_W-1:0] expected_states[$];
        int              errors;
        int              state_tally[3];

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_CAL_FRAMES: cal_frames = val[CAL_W-1:0];
                REG_THR_FACTOR: thr_factor = val[FACT_W-1:0];
                REG_MIN_SPEECH: min_speech = val[RUN_W-1:0];
                REG_HANGOVER:   hangover   = val[RUN_W-1:0];
                default: ;
            endcase
        endfunction

        // Accumulate one accepted sample; on frame end predict the frame state
        function void note_sample(logic [SAMPLE_W-1:0] smp, logic fend, logic [PROB_W-1:0] prob);
            longint unsigned mag, mean, root, trial;
            logic [FS_W-1:0] st;
            bit              speech;
            mag = smp[SAMPLE_W-1] ? (17'h10000 - smp) : smp;
            // samples past the frame limit are dropped, frame-end one included
            if (sample_count < MAX_FRAME) begin
                energy_sum   += mag * mag;
                sample_count += 1;
            end
            if (!fend) return;

            // integer square root of the floored mean square, bit by bit
            mean = energy_sum / sample_count;
            root = 0;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= mean) root = trial;
            end
            energy_sum   = '0;
            sample_count = '0;

            st = FS_SILENCE;
            if (calib_count < cal_frames) begin
                // calibration: average frame RMS into the floor, never below the minimum
                calib_sum   += root;
                calib_count += 1;
                if (calib_count == cal_frames) begin
                    mean        = calib_sum / cal_frames;
                    floor_level = (mean < FLOOR_MIN) ? FLOOR_MIN : 16'(mean);
                end
            end else begin
                speech = (root * 16 > 64'(floor_level) * thr_factor) || (prob > PROB_LIMIT);
                if (!talking) begin
                    if (speech) begin
                        speech_run  = (speech_run < RUN_MAX) ? speech_run + 1'b1 : RUN_MAX;
                        silence_run = '0;
                        if (speech_run >= min_speech) begin
                            talking = 1'b1;
                            st      = FS_SPEECH;
                        end
                    end else begin
                        speech_run = '0;
                    end
                end else if (speech) begin
                    silence_run = '0;
                    st          = FS_SPEECH;
                end else begin
                    // hangover: silent frames still report speech until the run is long enough
                    silence_run = (silence_run < RUN_MAX) ? silence_run + 1'b1 : RUN_MAX;
                    st          = FS_SPEECH;
                    if (silence_run >= hangover) begin
                        talking     = 1'b0;
                        speech_run  = '0;
                        silence_run = '0;
                        st          = FS_END;
                    end
                end
            end
            expected_states.push_back(st);
            state_tally[st]++;
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_frame_state(logic [M_DATA_W-1:0] got);
            logic [M_DATA_W-1:0] want;
            if (expected_states.size() == 0) begin
                $display("%0t: frame state %h arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = '0;
            want[FS_W-1:0] = expected_states.pop_front();
            if (got !== want) begin
                $display("%0t: frame state mismatch: expected %h, got %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_states.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;  // [15:0] sample, [23:16] speech_prob
    logic                  s_tlast   = 1'b0; // frame_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // [1:0] frame_state, rest zero

    frame_state_scoreboard frame_sb = new();
    bit                    no_idle = 1'b0;
    int                    samples_sent;
    int                    settings_run;
    int                    quiet_cycles;

    energy_voice_activity_detector_core #(
        .MAX_FRAME(MAX_FRAME)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver side: random stalls, none in the no-idle phase
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 9);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            frame_sb.check_frame_state(m_tdata);
        end
    end

    // Watchdog: ends the run when no request moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        frame_sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    // Load all four registers back to back; the core is idle here
    task automatic program_regs(input logic [CFG_W-1:0] cal, input logic [CFG_W-1:0] fac,
                                input logic [CFG_W-1:0] mins, input logic [CFG_W-1:0] hang);
        write_reg(REG_CAL_FRAMES, cal);
        write_reg(REG_THR_FACTOR, fac);
        write_reg(REG_MIN_SPEECH, mins);
        write_reg(REG_HANGOVER, hang);
        cfg_wr_en <= 1'b0;
        settings_run++;
    endtask

    // Drive one sample request and hold it until the core takes it.
    // Entered and left at a falling edge; tvalid stays high unless a gap is taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic fend,
                               input logic [PROB_W-1:0] prob);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 9) gap = $urandom_range(1, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prob, smp};
        s_tlast  <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_sb.note_sample(smp, fend, prob);
        samples_sent++;
        @(negedge aclk);
    endtask

    // Drop tvalid, let every predicted state arrive, then let the core settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random frames; loudness and probability band are sticky so speech and
    // silence runs build up across frames
    task automatic run_random_phase(input int n_items);
        int              stop_at, len, level, span;
        bit              prob_hi;
        logic [PROB_W-1:0] fprob;
        stop_at = samples_sent + n_items;
        level   = $urandom_range(0, 15);
        prob_hi = 1'b0;
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 15);
            if ($urandom_range(0, 4) == 0) prob_hi = !prob_hi;
            span  = 1 << level;
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            fprob = prob_hi ? PROB_W'($urandom_range(150, 255))
                            : PROB_W'($urandom_range(0, 156));
            for (int i = 0; i < len; i++) begin
                send_sample(16'(int'($urandom_range(0, 2 * span - 1)) - span), i == len - 1,
                            (i == len - 1) ? fprob : 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: two calibration frames, thresholds of one frame
        program_regs(10'd2, 10'd16, 10'd1, 10'd1);
        // silent calibration frame; probability is ignored while calibrating
        send_sample(16'h0000, 1'b1, 8'hFF);
        // overlong calibration frame: the loud tail beyond the limit is dropped,
        // so the floor is 40 and gets raised to the minimum of 50
        for (int i = 0; i < MAX_FRAME; i++) begin
            send_sample(i[0] ? -16'sd80 : 16'sd80, 1'b0, 8'($urandom_range(0, 255)));
        end
        repeat (5) send_sample(16'h8000, 1'b0, 8'($urandom_range(0, 255)));
        send_sample(16'h7FFF, 1'b1, 8'h00);
        // energy at the floor is not speech, one above it is
        send_sample(16'sd50, 1'b1, 8'h00);
        send_sample(-16'sd51, 1'b1, 8'h00);
        // probability just above and at its limit, hangover of one frame
        send_sample(16'h0000, 1'b1, 8'd154);
        send_sample(16'h0000, 1'b1, PROB_LIMIT);
        // alternating bit patterns and full-scale samples
        send_sample(16'h5555, 1'b0, 8'h00);
        send_sample(16'hAAAA, 1'b1, 8'h55);
        send_sample(16'h7FFF, 1'b0, 8'h00);
        send_sample(16'h8000, 1'b1, 8'hAA);
        send_sample(16'h0001, 1'b1, 8'h00);
        drain();

        // Random phases over a range of register settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: program_regs(10'd6, 10'd48, 10'd3, 10'd5);        // calibration resumes
                1: program_regs(10'd0, 10'd255, 10'd2, 10'd4);       // calibration skipped
                2: program_regs(10'd1, 10'd0, 10'd0, 10'd0);         // zero thresholds
                3: program_regs(10'd30, 10'd24, 10'd4, 10'd8);
                4: program_regs(10'd1023, 10'd200, 10'd1023, 10'd1023);
                5: program_regs(10'd0, 10'd20, 10'd1, 10'd3);        // ends calibration at once
                default: program_regs(10'd0, 10'($urandom_range(0, 255)),
                                      10'($urandom_range(0, 6)), 10'($urandom_range(0, 12)));
            endcase
            no_idle = (p == 3);
            run_random_phase(PHASE_ITEMS);
            drain();
        end

        $display("Covered %0d samples in %0d frames over %0d register settings.",
                 samples_sent, frame_sb.state_tally[0] + frame_sb.state_tally[1] +
                 frame_sb.state_tally[2], settings_run);
        $display("Frame states: %0d silence, %0d speech, %0d speech ended.",
                 frame_sb.state_tally[FS_SILENCE], frame_sb.state_tally[FS_SPEECH],
                 frame_sb.state_tally[FS_END]);
        if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vad_pkg.sv
hw/rtl/vad_div.sv
hw/rtl/vad_isqrt.sv
hw/rtl/energy_voice_activity_detector_core.sv
verif/energy_voice_activity_detector_core_tb.sv
